// ===== rtl/itsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itsh_pkg
// shared widths, defaults and state codes of the id table search block
// ----------------------------------------------------------------------------
package itsh_pkg;

	localparam int SIZE_W            = 11;
	localparam int SLOT_W            = 10;
	localparam int ID_W              = 32;
	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int SIZE_MAX          = (1 << SIZE_W) - 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PROBE = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

endpackage

// ===== rtl/id_table_search_with_hint_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_table_search_with_hint_top
// maps a global id to its 1-based table position, probing a hint entry first
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries command, slot and id_value.
// A load item (command 0) writes id_value into the table entry at slot
// if slot lies within the table, and gives no result; the next item is
// taken in the next cycle. A query item (command 1) gives one result item
// (found, position) on the output channel (out_valid / out_stall). The
// query reads one table entry per cycle from a memory with separate read
// and write ports: one read at the hint if it lies below table_size, then
// on a miss a scan from entry 0 that stops at the first match or at the
// end of the table. in_stall is high while a query is being worked on.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver still stalls when a later query finishes, that
// query holds until the register frees.
// table_size is written over the cfg channel (cfg_valid / cfg_ready) and
// is taken at any time. Reset clears the hint, table_size and all control
// state; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module id_table_search_with_hint_top #(
	parameter int TABLE_DEPTH = itsh_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [itsh_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [itsh_pkg::SLOT_W-1:0]       slot,
	input  logic signed [itsh_pkg::ID_W-1:0]  id_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [itsh_pkg::SIZE_W-1:0]       position
);

	localparam int SW = itsh_pkg::SIZE_W;
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int XW = (AW > SW) ? AW : SW;
	localparam logic [SW-1:0] DEPTH_LIM =
		SW'((TABLE_DEPTH > itsh_pkg::SIZE_MAX) ? itsh_pkg::SIZE_MAX : TABLE_DEPTH);

	itsh_pkg::state_t state_q, state_d;

	logic [SW-1:0]                size_q;
	logic [SW-1:0]                hint_q;
	logic [SW-1:0]                idx_q, idx_d;
	logic [SW-1:0]                n_q, n_cur;
	logic [itsh_pkg::ID_W-1:0]    id_q;
	logic                         res_found_q, res_found_d;
	logic [SW-1:0]                res_pos_q, res_pos_d;
	logic                         out_valid_q, found_q;
	logic [SW-1:0]                position_q;

	logic [itsh_pkg::ID_W-1:0]    mem [TABLE_DEPTH];
	logic [itsh_pkg::ID_W-1:0]    rd_data_q;
	logic [SW-1:0]                rd_idx;
	logic [XW-1:0]                rd_ext, wr_ext;
	logic [AW-1:0]                rd_addr, wr_addr;

	logic in_acc, load_we, query_acc, out_free, hit;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != itsh_pkg::S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_we   = in_acc && !command && (32'(slot) < 32'(TABLE_DEPTH));
	assign query_acc = in_acc && command;
	assign out_free  = !out_valid_q || !out_stall;
	assign n_cur     = (size_q > DEPTH_LIM) ? DEPTH_LIM : size_q;
	assign hit       = (rd_data_q == id_q);

	assign rd_ext  = XW'(rd_idx);
	assign rd_addr = rd_ext[AW-1:0];
	assign wr_ext  = XW'(slot);
	assign wr_addr = wr_ext[AW-1:0];

	// table memory, at most one write and one read per cycle
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[wr_addr] <= id_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		res_found_d = res_found_q;
		res_pos_d   = res_pos_q;
		rd_idx      = '0;
		unique case (state_q)
			itsh_pkg::S_IDLE: begin
				if (query_acc) begin
					if (hint_q < n_cur) begin
						rd_idx  = hint_q;
						state_d = itsh_pkg::S_PROBE;
					end else if (n_cur == '0) begin
						res_found_d = 1'b0;
						res_pos_d   = '0;
						state_d     = itsh_pkg::S_DONE;
					end else begin
						rd_idx  = '0;
						idx_d   = '0;
						state_d = itsh_pkg::S_SCAN;
					end
				end
			end
			itsh_pkg::S_PROBE: begin
				if (hit) begin
					res_found_d = 1'b1;
					res_pos_d   = hint_q + SW'(1);
					state_d     = itsh_pkg::S_DONE;
				end else begin
					rd_idx  = '0;
					idx_d   = '0;
					state_d = itsh_pkg::S_SCAN;
				end
			end
			itsh_pkg::S_SCAN: begin
				if (hit) begin
					res_found_d = 1'b1;
					res_pos_d   = idx_q + SW'(1);
					state_d     = itsh_pkg::S_DONE;
				end else if (idx_q + SW'(1) == n_q) begin
					res_found_d = 1'b0;
					res_pos_d   = '0;
					state_d     = itsh_pkg::S_DONE;
				end else begin
					idx_d  = idx_q + SW'(1);
					rd_idx = idx_q + SW'(1);
				end
			end
			itsh_pkg::S_DONE: begin
				if (out_free) begin
					state_d = itsh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = itsh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itsh_pkg::S_IDLE;
			size_q      <= '0;
			hint_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			if (state_q == itsh_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				hint_q      <= res_found_q ? res_pos_q : n_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		res_found_q <= res_found_d;
		res_pos_q   <= res_pos_d;
		if (query_acc) begin
			id_q <= id_value;
			n_q  <= n_cur;
		end
		if (state_q == itsh_pkg::S_DONE && out_free) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

endmodule

// ===== rtl/itsh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itsh_checker
// port-level checks of the id table search block, bound to the top level
// ----------------------------------------------------------------------------
module itsh_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         command,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         found,
	input logic [itsh_pkg::SIZE_W-1:0]  position
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
		else $error("stalled result item changed");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("miss with nonzero position");

	// a hit reports a 1-based position
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> position != '0)
		else $error("hit with position zero");

	// load items never hold the input
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !command |=> !in_stall)
		else $error("stall after load item");

	// a query item occupies the block
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command |=> in_stall)
		else $error("no stall after query item");

endmodule

bind id_table_search_with_hint_top itsh_checker u_itsh_checker (.*);
